/* design/assert_macros.svh */
// Assertion helpers shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/utfx_pkg.sv */
`default_nettype none

package utfx_pkg;

	// Register indexes of the configuration port.
	localparam logic [1:0] CFG_IN_FORMAT  = 2'd0;
	localparam logic [1:0] CFG_OUT_FORMAT = 2'd1;
	localparam logic [1:0] CFG_ERROR_MODE = 2'd2;

	// Input encodings.
	localparam logic [1:0] IN_UTF16BE = 2'd0;
	localparam logic [1:0] IN_UTF16LE = 2'd1;
	localparam logic [1:0] IN_UTF32BE = 2'd2;
	localparam logic [1:0] IN_UTF32LE = 2'd3;

	// Output encodings.
	localparam logic [2:0] OUT_UTF8    = 3'd0;
	localparam logic [2:0] OUT_UTF16BE = 3'd1;
	localparam logic [2:0] OUT_UTF16LE = 3'd2;
	localparam logic [2:0] OUT_UTF32BE = 3'd3;
	localparam logic [2:0] OUT_UTF32LE = 3'd4;

	// Error handling modes.
	localparam logic [1:0] ERR_IGNORE  = 2'd0;
	localparam logic [1:0] ERR_REPLACE = 2'd1;
	localparam logic [1:0] ERR_ABORT   = 2'd2;

	// Kinds of request passed from the front end to the back end.
	localparam logic [1:0] CMD_POINT   = 2'd0;
	localparam logic [1:0] CMD_REPLACE = 2'd1;
	localparam logic [1:0] CMD_FLAG    = 2'd2;

	localparam logic [15:0] SURR_LEAD_LO  = 16'hD800;
	localparam logic [15:0] SURR_LEAD_HI  = 16'hDBFF;
	localparam logic [15:0] SURR_TRAIL_LO = 16'hDC00;
	localparam logic [15:0] SURR_TRAIL_HI = 16'hDFFF;
	localparam logic [31:0] CP_REPL       = 32'h0000FFFD;
	localparam logic [31:0] CP_MAX        = 32'h0010FFFF;
	localparam logic [20:0] CP_SUPP       = 21'h010000;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] cp;
	} cmd_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last;
	} enc_t;

	// Turns one code point into its run of output bytes; bytes[0] goes out first.
	function automatic enc_t encode_point(input logic [31:0] cp, input logic [2:0] fmt);
		enc_t        e;
		logic [2:0]  f;
		logic [20:0] c;
		logic [19:0] v;
		logic [15:0] u0;
		logic [15:0] u1;
		e.bytes = '0;
		e.last  = 2'd0;
		f = (fmt > OUT_UTF32LE) ? OUT_UTF8 : fmt;
		c = (cp > CP_MAX) ? CP_REPL[20:0] : cp[20:0];
		v = 20'(c - CP_SUPP);
		u0 = {6'b110110, v[19:10]};
		u1 = {6'b110111, v[9:0]};
		case (f)
			OUT_UTF32BE: begin
				e.bytes[0] = cp[31:24];
				e.bytes[1] = cp[23:16];
				e.bytes[2] = cp[15:8];
				e.bytes[3] = cp[7:0];
				e.last = 2'd3;
			end
			OUT_UTF32LE: begin
				e.bytes[0] = cp[7:0];
				e.bytes[1] = cp[15:8];
				e.bytes[2] = cp[23:16];
				e.bytes[3] = cp[31:24];
				e.last = 2'd3;
			end
			OUT_UTF16BE, OUT_UTF16LE: begin
				if (c < CP_SUPP) begin
					u0 = c[15:0];
					e.last = 2'd1;
				end else begin
					e.last = 2'd3;
				end
				if (f == OUT_UTF16LE) begin
					e.bytes[0] = u0[7:0];
					e.bytes[1] = u0[15:8];
					e.bytes[2] = u1[7:0];
					e.bytes[3] = u1[15:8];
				end else begin
					e.bytes[0] = u0[15:8];
					e.bytes[1] = u0[7:0];
					e.bytes[2] = u1[15:8];
					e.bytes[3] = u1[7:0];
				end
			end
			default: begin
				if (c < 21'h80) begin
					e.bytes[0] = c[7:0];
					e.last = 2'd0;
				end else if (c < 21'h800) begin
					e.bytes[0] = {3'b110, c[10:6]};
					e.bytes[1] = {2'b10, c[5:0]};
					e.last = 2'd1;
				end else if (c < CP_SUPP) begin
					e.bytes[0] = {4'b1110, c[15:12]};
					e.bytes[1] = {2'b10, c[11:6]};
					e.bytes[2] = {2'b10, c[5:0]};
					e.last = 2'd2;
				end else begin
					e.bytes[0] = {5'b11110, c[20:18]};
					e.bytes[1] = {2'b10, c[17:12]};
					e.bytes[2] = {2'b10, c[11:6]};
					e.bytes[3] = {2'b10, c[5:0]};
					e.last = 2'd3;
				end
			end
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

/* design/utf16_utf32_transcoder.sv */
// UTF-16 / UTF-32 byte stream transcoder.
// Input channel: one request per byte (in_valid, in_stall, in_byte) in the encoding
// chosen by in_format. Output channel: one request per output byte (out_valid,
// out_stall, out_byte, byte_valid, error_flag, run_last); run_last marks the final
// byte of the run produced for one code point or one malformed unit.
// Configuration: cfg_we writes cfg_wdata into the register chosen by cfg_index
// (0 in_format, 1 out_format, 2 error_mode); write only while the block is idle.
// Throughput: one input byte per cycle is taken while the request queue has room,
// and one output byte per cycle is delivered while out_stall is low; a code point
// of two or four input bytes yields one to four output bytes, so the output side
// sets the sustained rate. A completed code point is written into the queue, then
// loaded into the back end run register; each byte leaves through the output register.
// Reset clears the byte position, the halt flag, the queue and the output valid flag,
// and loads in_format 0, out_format 0, error_mode 1 (replace).
// When the receiver stalls, the output byte holds, the run waits, then the queue
// fills and in_stall rises; nothing is dropped. In abort mode a lone trailing
// surrogate gives one flag-only request, after which input bytes are accepted
// and discarded until reset.
`default_nettype none

module utf16_utf32_transcoder import utfx_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [2:0] cfg_wdata,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            error_flag,
	output logic            run_last
);

	// Configuration registers.
	logic [1:0] in_format_q;
	logic [2:0] out_format_q;
	logic [1:0] error_mode_q;

	// Front end to queue, queue to back end.
	logic push;
	cmd_t push_cmd;
	cmd_t q_head;
	logic q_empty;
	logic q_full;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_format_q  <= IN_UTF16BE;
			out_format_q <= OUT_UTF8;
			error_mode_q <= ERR_REPLACE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IN_FORMAT:  in_format_q  <= cfg_wdata[1:0];
				CFG_OUT_FORMAT: out_format_q <= cfg_wdata;
				CFG_ERROR_MODE: error_mode_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// The front end classifies every completed unit and pushes one request.
	utfx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_format  (in_format_q),
		.error_mode (error_mode_q),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	// The queue lets the front end keep taking bytes while a long run drains.
	utfx_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// The back end encodes the head request and streams its bytes.
	utfx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.out_format (out_format_q),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.error_flag (error_flag),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire

/* design/utfx_front.sv */
`default_nettype none

// Gathers input bytes into code units and code points and classifies them.
module utfx_front import utfx_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic [1:0] in_format,
	input  wire logic [1:0] error_mode,
	input  wire logic       q_full,
	output logic            push,
	output cmd_t            cmd
);

	logic [2:0][7:0] unit_q;
	logic [1:0]      pos_q;
	logic            halted_q;

	logic            accept;
	logic [1:0]      pos_next;
	logic            halt_set;
	logic [31:0]     cp32;
	logic [15:0]     cu;
	logic [15:0]     lead;
	logic [15:0]     trail;
	logic [21:0]     lead_off;
	logic [31:0]     pair_cp;
	logic            le16;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full && !halted_q;
	assign le16     = (in_format == IN_UTF16LE);

	always_comb begin
		cp32 = (in_format == IN_UTF32LE) ? {in_byte, unit_q[2], unit_q[1], unit_q[0]}
			: {unit_q[0], unit_q[1], unit_q[2], in_byte};
		cu    = le16 ? {in_byte, unit_q[0]} : {unit_q[0], in_byte};
		lead  = le16 ? {unit_q[1], unit_q[0]} : {unit_q[0], unit_q[1]};
		trail = le16 ? {in_byte, unit_q[2]} : {unit_q[2], in_byte};
		// The pair formula works modulo 2**32, so only the low 22 bits of the
		// lead offset survive the shift by ten.
		lead_off = {6'd0, lead} - {6'd0, SURR_LEAD_LO};
		pair_cp  = {lead_off, 10'd0} + {16'd0, trail} + 32'h00002400;
	end

	always_comb begin
		push     = 1'b0;
		cmd.kind = CMD_POINT;
		cmd.cp   = cp32;
		halt_set = 1'b0;
		pos_next = (pos_q == 2'd3) ? 2'd3 : pos_q + 2'd1;
		if (in_format[1]) begin
			if (pos_q == 2'd3) begin
				push     = 1'b1;
				pos_next = 2'd0;
			end
		end else begin
			case (pos_q)
				2'd1: begin
					cmd.cp = {16'd0, cu};
					if (!(cu inside {[SURR_LEAD_LO:SURR_LEAD_HI]})) begin
						pos_next = 2'd0;
						push     = 1'b1;
						if (cu inside {[SURR_TRAIL_LO:SURR_TRAIL_HI]}) begin
							case (error_mode)
								ERR_REPLACE: cmd.kind = CMD_REPLACE;
								ERR_ABORT: begin
									cmd.kind = CMD_FLAG;
									halt_set = 1'b1;
								end
								default: cmd.kind = CMD_FLAG;
							endcase
						end
					end
				end
				2'd3: begin
					cmd.cp   = pair_cp;
					push     = 1'b1;
					pos_next = 2'd0;
				end
				default: ;
			endcase
		end
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 2'd0;
			halted_q <= 1'b0;
		end else if (accept) begin
			pos_q <= pos_next;
			if (halt_set)
				halted_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_q != 2'd3)
			unit_q[pos_q] <= in_byte;
	end

endmodule

`default_nettype wire

/* design/utfx_queue.sv */
`default_nettype none

// Short first-in first-out queue of requests between front and back end.
module utfx_queue import utfx_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_FULL);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

/* design/utfx_back.sv */
`default_nettype none

// Encodes queued requests into byte runs and hands them out one byte a cycle while out_stall is low.
module utfx_back import utfx_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [2:0] out_format,
	input  wire logic       q_empty,
	input  wire cmd_t       q_head,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            error_flag,
	output logic            run_last
);

	logic            run_valid_q;
	logic [3:0][7:0] run_bytes_q;
	logic [1:0]      run_end_q;
	logic [1:0]      run_idx_q;
	logic            run_err_q;
	logic            run_dv_q;

	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            byte_valid_q;
	logic            error_flag_q;
	logic            run_last_q;

	logic            out_free;
	logic            advance;
	logic            run_done;
	enc_t            enc;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = run_valid_q && out_free;
	assign run_done = advance && (run_idx_q == run_end_q);
	assign pop      = !q_empty && (!run_valid_q || run_done);

	always_comb begin
		enc = encode_point((q_head.kind == CMD_REPLACE) ? CP_REPL : q_head.cp, out_format);
		if (q_head.kind == CMD_FLAG) begin
			enc.bytes = '0;
			enc.last  = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			run_idx_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				run_valid_q <= 1'b1;
				run_idx_q   <= 2'd0;
			end else if (run_done) begin
				run_valid_q <= 1'b0;
			end else if (advance) begin
				run_idx_q <= run_idx_q + 2'd1;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_free)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			run_bytes_q <= enc.bytes;
			run_end_q   <= enc.last;
			run_err_q   <= (q_head.kind != CMD_POINT);
			run_dv_q    <= (q_head.kind != CMD_FLAG);
		end
		if (advance) begin
			out_byte_q   <= run_bytes_q[run_idx_q];
			byte_valid_q <= run_dv_q;
			error_flag_q <= run_err_q;
			run_last_q   <= (run_idx_q == run_end_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign error_flag = error_flag_q;
	assign run_last   = run_last_q;

endmodule

`default_nettype wire

/* design/utfx_checker.sv */
`default_nettype none

`include "assert_macros.svh"

// Watches the output channel of the transcoder.
module utfx_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       byte_valid,
	input wire logic       error_flag,
	input wire logic       run_last
);

	// A stalled request stays on the port unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last), "stalled output request changed")

	// A flag-only request is an error and closes its run by itself.
	`ASSERT_ALWAYS(a_flag_only, clk, arst_n, !(out_valid && !byte_valid) || (error_flag && run_last && out_byte == 8'd0), "flag-only request malformed")

	// Bytes of one run follow one another without gaps.
	`ASSERT_NEXT(a_run_gapless, clk, arst_n, out_valid && !out_stall && !run_last, out_valid, "gap inside an output run")

	// The error mark is the same on every byte of a run.
	`ASSERT_NEXT(a_run_err, clk, arst_n, out_valid && !out_stall && !run_last, error_flag == $past(error_flag) && byte_valid, "error mark changed within a run")

endmodule

bind utf16_utf32_transcoder utfx_checker u_checker (.*);

`default_nettype wire
